[rtl/core/ncv_pkg.sv]
package ncv_pkg;

    // Character codes used by the sentence parser
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] HEX_A_VAL  = 8'd10;

    // Room that must remain after the star: star, two digits, line end
    localparam logic [8:0] STAR_ROOM  = 9'd4;
    localparam logic [7:0] POS_MAX    = 8'd255;

    localparam logic [7:0] LIMIT_RESET = 8'd128;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_HEX1 = 3'd2,
        PH_HEX2 = 3'd3,
        PH_TAIL = 3'd4,
        PH_LATE = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_MATCH    = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_BAD_HEX  = 2'd2,
        ST_NO_STAR  = 2'd3
    } t_status;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] xor_acc;
        logic [7:0] pos;
        logic [7:0] rx_val;
        logic       hex_err;
        logic       restart;
    } t_state;

    typedef struct packed {
        t_status    status;
        logic [7:0] computed;
        logic [7:0] received;
        logic       unexpected_start;
    } t_result;

    // Decode one upper-case hex digit; invalid digits give zero
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = c - CH_UPPER_A + HEX_A_VAL;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

[rtl/core/nmea_checksum_validator_core.sv]
// NMEA 0183 checksum checker. Bytes enter on the rx channel at up to one per
// clock; bytes before a '$' are dropped, the rest are XORed up to '*', the two
// hex digits after it are decoded, and each '\n' that closes an open sentence
// yields one result (status, both checksums, restart flag): the newline is
// held in the input register, then the result in the result register. Only
// a newline waiting behind a stalled result blocks the input; other bytes flow
// through the combinational parser step. The user must write the sentence limit
// register via i_cfg_we/i_cfg_data only while idle; the block does not enforce it.
module nmea_checksum_validator_core
    import ncv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_computed_checksum,
    output logic [7:0] o_received_checksum,
    output logic       o_unexpected_start
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [7:0] r_limit;
    t_state     r_state;
    t_state     n_state;
    logic       emit;
    logic       out_free;
    logic       fire;
    t_result    step_result;
    t_result    res;

    ncv_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_limit  (r_limit),
        .o_next   (n_state),
        .o_emit   (emit),
        .o_result (step_result)
    );

    ncv_result_reg u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && emit),
        .i_result (step_result),
        .i_stall  (i_res_stall),
        .o_free   (out_free),
        .o_valid  (o_res_valid),
        .o_result (res)
    );

    // Advance the parser unless a result has nowhere to go
    assign fire       = r_in_valid && (out_free || !emit);
    assign o_rx_stall = r_in_valid && !fire;

    // Capture incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_rx_stall) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_rx_stall && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Update sentence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, xor_acc: 8'd0, pos: 8'd0, rx_val: 8'd0,
                         hex_err: 1'b0, restart: 1'b0};
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // Hold the sentence limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    assign o_status            = res.status;
    assign o_computed_checksum = res.computed;
    assign o_received_checksum = res.received;
    assign o_unexpected_start  = res.unexpected_start;

endmodule

[rtl/core/ncv_step.sv]
module ncv_step
    import ncv_pkg::*;
(
    input  t_state      i_state,
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_limit,
    output t_state      o_next,
    output logic        o_emit,
    output t_result     o_result
);

    logic [7:0] pos_inc;
    logic [8:0] star_end;
    logic [4:0] nib;

    assign pos_inc  = (i_state.pos < POS_MAX) ? i_state.pos + 8'd1 : i_state.pos;
    assign star_end = {1'b0, pos_inc} + STAR_ROOM;
    assign nib      = hex_nibble(i_byte);

    // Work out the next parser state and any result for this byte
    always_comb begin
        o_next   = i_state;
        o_emit   = 1'b0;
        o_result.computed         = i_state.xor_acc;
        o_result.received         = (i_state.phase == PH_LATE) ? 8'd0 : i_state.rx_val;
        o_result.unexpected_start = i_state.restart;
        priority if (i_state.phase != PH_TAIL) begin
            o_result.status = ST_NO_STAR;
        end else if (i_state.hex_err) begin
            o_result.status = ST_BAD_HEX;
        end else if (i_state.xor_acc == i_state.rx_val) begin
            o_result.status = ST_MATCH;
        end else begin
            o_result.status = ST_MISMATCH;
        end

        priority if (i_byte == CH_DOLLAR) begin
            // open or restart a sentence
            o_next.phase   = PH_BODY;
            o_next.xor_acc = 8'd0;
            o_next.pos     = 8'd0;
            o_next.rx_val  = 8'd0;
            o_next.hex_err = 1'b0;
            o_next.restart = (i_state.phase != PH_IDLE);
        end else if (i_state.phase == PH_IDLE) begin
            // drop bytes outside a sentence
        end else if (i_byte == CH_LF) begin
            o_emit         = 1'b1;
            o_next.phase   = PH_IDLE;
            o_next.restart = 1'b0;
        end else begin
            o_next.pos = pos_inc;
            unique case (i_state.phase)
                PH_BODY: begin
                    if (i_byte == CH_STAR) begin
                        o_next.phase = (star_end <= {1'b0, i_limit}) ? PH_HEX1 : PH_LATE;
                    end else begin
                        o_next.xor_acc = i_state.xor_acc ^ i_byte;
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    o_next.rx_val  = {i_state.rx_val[3:0], nib[3:0]};
                    o_next.hex_err = i_state.hex_err | ~nib[4];
                    o_next.phase   = (i_state.phase == PH_HEX1) ? PH_HEX2 : PH_TAIL;
                end
                default: begin
                    // tail and late phases ignore bytes
                end
            endcase
        end
    end

endmodule

[rtl/core/ncv_result_reg.sv]
module ncv_result_reg
    import ncv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    input  logic       i_stall,
    output logic       o_free,
    output logic       o_valid,
    output t_result    o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Hold a result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[rtl/core/ncv_checker.sv]
module ncv_checker
    import ncv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_rx_stall,
    input  logic       o_res_valid,
    input  logic       i_res_stall,
    input  logic [1:0] o_status,
    input  logic [7:0] o_computed_checksum,
    input  logic [7:0] o_received_checksum,
    input  logic       o_unexpected_start
);

    // A stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_status)
            && $stable(o_computed_checksum) && $stable(o_received_checksum)
            && $stable(o_unexpected_start))
        else $error("stalled result changed");

    // Reset leaves no result pending
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // Match status only with equal checksums
    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == ST_MATCH |-> o_computed_checksum == o_received_checksum)
        else $error("match with differing checksums");

    // Mismatch status only with differing checksums
    a_mismatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == ST_MISMATCH
            |-> o_computed_checksum != o_received_checksum)
        else $error("mismatch with equal checksums");

    // Input stalls only behind a stalled result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid && i_res_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind nmea_checksum_validator_core ncv_checker u_ncv_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_rx_stall          (o_rx_stall),
    .o_res_valid         (o_res_valid),
    .i_res_stall         (i_res_stall),
    .o_status            (o_status),
    .o_computed_checksum (o_computed_checksum),
    .o_received_checksum (o_received_checksum),
    .o_unexpected_start  (o_unexpected_start)
);
